>>> design/abcl_pkg.sv
// package for the circular list engine: operation and status codes, sizes
// no dependencies
`default_nettype none
package abcl_pkg;
  localparam int unsigned CAPACITY_DEF   = 16;
  localparam int unsigned DATA_WIDTH_DEF = 32;

  localparam logic [3:0] OP_PUSH_FRONT = 4'd0;
  localparam logic [3:0] OP_PUSH_BACK  = 4'd1;
  localparam logic [3:0] OP_INSERT     = 4'd2;
  localparam logic [3:0] OP_REM_SLOT   = 4'd3;
  localparam logic [3:0] OP_REM_HEAD   = 4'd4;
  localparam logic [3:0] OP_REM_TAIL   = 4'd5;
  localparam logic [3:0] OP_RD_SLOT    = 4'd6;
  localparam logic [3:0] OP_RD_HEAD    = 4'd7;
  localparam logic [3:0] OP_RD_TAIL    = 4'd8;
  localparam logic [3:0] OP_CLEAR      = 4'd9;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_BAD   = 2'd3;
endpackage
`default_nettype wire

>>> design/array_backed_circular_list_engine.sv
// Circular doubly linked list engine over a fixed slot store. One transaction
// is one operation; the engine is busy from acceptance until its result is
// taken. A push or insert scans the occupancy map one slot per cycle to find
// the lowest free slot, an insert in the middle then walks the next links
// from the head with a read state and a step state per node, and link
// updates take up to four more single-port steps. A read passes S_CHK and
// S_RM_A to its result, a remove of any but the last node then relinks its
// neighbours in S_RM_B and S_RM_C, and clear sweeps the occupancy bits.
// Data and link stores are single-ported memories, one access per cycle.
// depends on abcl_pkg
`default_nettype none
module array_backed_circular_list_engine #(
  parameter int unsigned CAPACITY   = abcl_pkg::CAPACITY_DEF,
  parameter int unsigned DATA_WIDTH = abcl_pkg::DATA_WIDTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [3:0]  in_operation,
  input  wire logic [31:0] in_value,
  input  wire logic [3:0]  in_position,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_status,
  output logic [31:0]      out_data,
  output logic [3:0]       out_slot,
  output logic [4:0]       out_count
);
  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_WALK_RD, S_WALK, S_LNK_A, S_LNK_B, S_LNK_C, S_LNK_D,
    S_CHK, S_RM_A, S_RM_B, S_RM_C, S_CLR, S_DONE
  } state_t;

  state_t               state_r;
  logic [CAPACITY-1:0]  occ_r;
  logic [AW-1:0]        head_r, tail_r;
  logic [CW-1:0]        count_r;
  logic [3:0]           op_r;
  logic [DATA_WIDTH-1:0] val_r;
  logic [3:0]           pos_r;
  logic [AW-1:0]        idx_r;   // scan/sweep counter
  logic [3:0]           steps_r; // walk steps remaining
  logic [AW-1:0]        s_r, p_r, b_r, n_r;
  logic                 front_r;
  logic [1:0]           status_r;
  logic [31:0]          data_r;
  logic [3:0]           slot_r;

  // single-port memories
  logic [DATA_WIDTH-1:0] dmem [CAPACITY];
  logic [AW-1:0]         nmem [CAPACITY];
  logic [AW-1:0]         pmem [CAPACITY];
  logic [DATA_WIDTH-1:0] drd_r;
  logic [AW-1:0]         nrd_r, prd_r;
  logic                  dwe, nwe, pwe;
  logic [AW-1:0]         daddr, naddr, paddr;
  logic [DATA_WIDTH-1:0] dwd;
  logic [AW-1:0]         nwd, pwd;

  always_ff @(posedge clk) begin
    if (dwe) dmem[daddr] <= dwd;
    drd_r <= dmem[daddr];
  end
  always_ff @(posedge clk) begin
    if (nwe) nmem[naddr] <= nwd;
    nrd_r <= nmem[naddr];
  end
  always_ff @(posedge clk) begin
    if (pwe) pmem[paddr] <= pwd;
    prd_r <= pmem[paddr];
  end

  // memory port control per state
  always_comb begin
    dwe = 1'b0; nwe = 1'b0; pwe = 1'b0;
    daddr = s_r; naddr = s_r; paddr = s_r;
    dwd = val_r; nwd = p_r; pwd = b_r;
    unique case (state_r)
      S_WALK_RD, S_WALK: naddr = p_r;
      S_LNK_A: paddr = p_r;
      S_LNK_B: begin
        // first entry links to itself
        dwe = 1'b1; nwe = 1'b1; pwe = 1'b1;
        nwd = (count_r == '0) ? s_r : p_r;
        pwd = (count_r == '0) ? s_r : prd_r;
      end
      S_LNK_C: begin nwe = 1'b1; naddr = b_r; nwd = s_r; end
      S_LNK_D: begin pwe = 1'b1; paddr = p_r; pwd = s_r; end
      S_CHK: begin daddr = s_r; naddr = s_r; paddr = s_r; end
      S_RM_B: begin nwe = 1'b1; naddr = p_r; nwd = n_r; end
      S_RM_C: begin pwe = 1'b1; paddr = n_r; pwd = p_r; end
      default: ;
    endcase
  end

  logic [AW-1:0] tgt;
  always_comb begin
    priority case (in_operation)
      abcl_pkg::OP_REM_HEAD, abcl_pkg::OP_RD_HEAD: tgt = head_r;
      abcl_pkg::OP_REM_TAIL, abcl_pkg::OP_RD_TAIL: tgt = tail_r;
      default: tgt = AW'(in_position);
    endcase
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_DONE);
  assign out_status = status_r;
  assign out_data   = data_r;
  assign out_slot   = slot_r;
  assign out_count  = 5'(count_r);

  logic is_rm;
  assign is_rm = (op_r == abcl_pkg::OP_REM_SLOT) || (op_r == abcl_pkg::OP_REM_HEAD) ||
                 (op_r == abcl_pkg::OP_REM_TAIL);

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; occ_r <= '0; head_r <= '0; tail_r <= '0; count_r <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: if (in_valid) begin
          op_r <= in_operation; val_r <= DATA_WIDTH'(in_value); pos_r <= in_position;
          s_r <= tgt; idx_r <= '0; status_r <= abcl_pkg::ST_BAD;
          data_r <= '0; slot_r <= '0;
          front_r <= (in_operation == abcl_pkg::OP_PUSH_FRONT) ||
                     (in_operation == abcl_pkg::OP_INSERT && in_position == 4'd0);
          steps_r <= in_position;
          priority case (1'b1)
            in_operation == abcl_pkg::OP_PUSH_FRONT ||
            in_operation == abcl_pkg::OP_PUSH_BACK:
              if (count_r >= CW'(CAPACITY)) begin
                status_r <= abcl_pkg::ST_FULL; state_r <= S_DONE;
              end else state_r <= S_SCAN;
            in_operation == abcl_pkg::OP_INSERT:
              if (32'(in_position) >= 32'(count_r)) state_r <= S_DONE;
              else if (count_r >= CW'(CAPACITY)) begin
                status_r <= abcl_pkg::ST_FULL; state_r <= S_DONE;
              end else state_r <= S_SCAN;
            in_operation >= abcl_pkg::OP_REM_SLOT &&
            in_operation <= abcl_pkg::OP_RD_TAIL:
              if (count_r == '0) begin
                status_r <= abcl_pkg::ST_EMPTY; state_r <= S_DONE;
              end else if (32'(in_position) >= CAPACITY &&
                           (in_operation == abcl_pkg::OP_REM_SLOT ||
                            in_operation == abcl_pkg::OP_RD_SLOT))
                state_r <= S_DONE;
              else if (!occ_r[tgt]) state_r <= S_DONE;
              else state_r <= S_CHK;
            in_operation == abcl_pkg::OP_CLEAR: begin
              status_r <= abcl_pkg::ST_OK; head_r <= '0; tail_r <= '0;
              count_r <= '0; state_r <= S_CLR;
            end
            default: state_r <= S_DONE;
          endcase
        end
        // lowest free slot, one per cycle
        S_SCAN: if (!occ_r[idx_r]) begin
          s_r <= idx_r; p_r <= head_r;
          if (count_r == '0) begin
            b_r <= idx_r; p_r <= idx_r; state_r <= S_LNK_B;
            front_r <= 1'b1;
          end else if (op_r == abcl_pkg::OP_INSERT && !front_r &&
                       32'(pos_r) != 32'(count_r) - 1) begin
            steps_r <= pos_r; state_r <= S_WALK_RD;
          end else state_r <= S_LNK_A;
        end else idx_r <= idx_r + 1'b1;
        S_WALK_RD: if (steps_r == '0) state_r <= S_LNK_A;
                   else state_r <= S_WALK;
        S_WALK: begin
          p_r <= nrd_r; steps_r <= steps_r - 1'b1; state_r <= S_WALK_RD;
        end
        S_LNK_A: state_r <= S_LNK_B;
        S_LNK_B: begin
          // an empty list takes the new node as both head and tail
          if (count_r == '0) begin
            head_r <= s_r; tail_r <= s_r; state_r <= S_LNK_D;
          end else begin
            b_r <= prd_r; state_r <= S_LNK_C;
          end
        end
        S_LNK_C: state_r <= S_LNK_D;
        S_LNK_D: begin
          if (count_r != '0) begin
            if (op_r == abcl_pkg::OP_PUSH_FRONT ||
                (op_r == abcl_pkg::OP_INSERT && pos_r == 4'd0)) head_r <= s_r;
            else if (op_r == abcl_pkg::OP_PUSH_BACK ||
                     32'(pos_r) == 32'(count_r) - 1) tail_r <= s_r;
          end
          occ_r[s_r] <= 1'b1; count_r <= count_r + 1'b1;
          status_r <= abcl_pkg::ST_OK; slot_r <= 4'(s_r); state_r <= S_DONE;
        end
        S_CHK: state_r <= S_RM_A;
        S_RM_A: begin
          status_r <= abcl_pkg::ST_OK; slot_r <= 4'(s_r); data_r <= 32'(drd_r);
          n_r <= nrd_r; p_r <= prd_r;
          if (!is_rm) state_r <= S_DONE;
          else begin
            occ_r[s_r] <= 1'b0; count_r <= count_r - 1'b1;
            if (count_r == CW'(1)) begin
              head_r <= '0; tail_r <= '0; state_r <= S_DONE;
            end else begin
              if (head_r == s_r) head_r <= nrd_r;
              if (tail_r == s_r) tail_r <= prd_r;
              state_r <= S_RM_B;
            end
          end
        end
        S_RM_B: state_r <= S_RM_C;
        S_RM_C: state_r <= S_DONE;
        // occupancy sweep
        S_CLR: begin
          occ_r[idx_r] <= 1'b0;
          if (32'(idx_r) == CAPACITY - 1) state_r <= S_DONE;
          else idx_r <= idx_r + 1'b1;
        end
        S_DONE: if (!out_stall) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // engine busy while a result is pending
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("accepted while result pending");
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY)) else $error("count overflow");
  a_ok_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != abcl_pkg::ST_OK) |-> (out_slot == 4'd0 && out_data == '0))
    else $error("error result carries data");
endmodule
`default_nettype wire

>>> verif/array_backed_circular_list_engine_tb.sv
// testbench for array_backed_circular_list_engine: directed and random list operations
// checked against a behavioral list model; depends on abcl_pkg and the engine rtl
`default_nettype none
module array_backed_circular_list_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSLOT = 16;

  typedef struct packed {
    logic [3:0]  op;
    logic [31:0] value;
    logic [3:0]  pos;
  } list_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] data;
    logic [3:0]  slot;
    logic [4:0]  count;
  } list_rsp_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic [3:0] in_operation = '0;
  logic [31:0] in_value = '0;
  logic [3:0] in_position = '0;
  logic out_stall = 1'b0;
  logic in_stall, out_valid;
  logic [1:0] out_status;
  logic [31:0] out_data;
  logic [3:0] out_slot;
  logic [4:0] out_count;

  array_backed_circular_list_engine DUT (
    .clk, .rst_n, .in_valid, .in_stall, .in_operation, .in_value, .in_position,
    .out_valid, .out_stall, .out_status, .out_data, .out_slot, .out_count
  );

  always #10 clk = ~clk;

  // list model state
  logic        m_used [NSLOT];
  logic [31:0] m_data [NSLOT];
  logic [3:0]  m_next [NSLOT];
  logic [3:0]  m_prev [NSLOT];
  logic [3:0]  m_head, m_tail;
  logic [4:0]  m_count;

  list_req_t pending_reqs[$];
  list_rsp_t expected_rsps[$];
  int errors = 0;
  int accepted = 0;
  int checked = 0;
  bit quiet_tail = 1'b0;
  bit hold_request = 1'b0;
  bit stim_done = 1'b0;

  function automatic int lowest_free();
    for (int i = 0; i < NSLOT; i++) if (!m_used[i]) return i;
    return NSLOT;
  endfunction

  function automatic void link_before(logic [3:0] s, logic [3:0] p);
    logic [3:0] b;
    b = m_prev[p];
    m_prev[s] = b;
    m_next[s] = p;
    m_next[b] = s;
    m_prev[p] = s;
  endfunction

  // push at an end; returns status and slot used
  function automatic logic [1:0] list_push(bit front, logic [31:0] v, output logic [3:0] s);
    int f;
    s = '0;
    if (m_count >= NSLOT) return abcl_pkg::ST_FULL;
    f = lowest_free();
    s = f[3:0];
    m_used[s] = 1'b1;
    m_data[s] = v;
    if (m_count == 0) begin
      m_next[s] = s; m_prev[s] = s; m_head = s; m_tail = s;
    end else begin
      link_before(s, m_head);
      if (front) m_head = s;
      else m_tail = s;
    end
    m_count++;
    return abcl_pkg::ST_OK;
  endfunction

  // compute the response for one request and update the model
  function automatic list_rsp_t apply_list_op(list_req_t r);
    list_rsp_t o;
    logic [3:0] tgt, s, p, n;
    int f;
    o = '0;
    o.status = abcl_pkg::ST_BAD;
    tgt = '0;
    case (r.op)
      abcl_pkg::OP_PUSH_FRONT: o.status = list_push(1'b1, r.value, o.slot);
      abcl_pkg::OP_PUSH_BACK:  o.status = list_push(1'b0, r.value, o.slot);
      abcl_pkg::OP_INSERT: begin
        if (r.pos >= m_count) o.status = abcl_pkg::ST_BAD;
        else if (r.pos == 0) o.status = list_push(1'b1, r.value, o.slot);
        else if (r.pos == m_count - 1) o.status = list_push(1'b0, r.value, o.slot);
        else if (m_count >= NSLOT) o.status = abcl_pkg::ST_FULL;
        else begin
          f = lowest_free();
          s = f[3:0];
          p = m_head;
          for (int i = 0; i < r.pos; i++) p = m_next[p];
          m_used[s] = 1'b1;
          m_data[s] = r.value;
          link_before(s, p);
          m_count++;
          o.slot = s;
          o.status = abcl_pkg::ST_OK;
        end
      end
      abcl_pkg::OP_REM_SLOT, abcl_pkg::OP_RD_SLOT: tgt = r.pos;
      abcl_pkg::OP_REM_HEAD, abcl_pkg::OP_RD_HEAD: tgt = m_head;
      abcl_pkg::OP_REM_TAIL, abcl_pkg::OP_RD_TAIL: tgt = m_tail;
      abcl_pkg::OP_CLEAR: begin
        for (int i = 0; i < NSLOT; i++) m_used[i] = 1'b0;
        m_head = '0; m_tail = '0; m_count = '0;
        o.status = abcl_pkg::ST_OK;
      end
      default: o.status = abcl_pkg::ST_BAD;
    endcase
    if (r.op >= abcl_pkg::OP_REM_SLOT && r.op <= abcl_pkg::OP_RD_TAIL) begin
      if (m_count == 0) o.status = abcl_pkg::ST_EMPTY;
      else if (!m_used[tgt]) o.status = abcl_pkg::ST_BAD;
      else begin
        o.status = abcl_pkg::ST_OK;
        o.slot = tgt;
        o.data = m_data[tgt];
        if (r.op <= abcl_pkg::OP_REM_TAIL) begin
          n = m_next[tgt]; p = m_prev[tgt];
          m_used[tgt] = 1'b0;
          m_count--;
          if (m_count == 0) begin
            m_head = '0; m_tail = '0;
          end else begin
            m_next[p] = n; m_prev[n] = p;
            if (m_head == tgt) m_head = n;
            if (m_tail == tgt) m_tail = p;
          end
        end
      end
    end
    if (o.status != abcl_pkg::ST_OK) begin
      o.slot = '0; o.data = '0;
    end
    o.count = m_count;
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch on %s: got %0h expected %0h (result %0d)", what, got, want, checked);
    errors++;
  endtask

  // driver: one transaction at a time from the pending queue, random gaps
  int send_gap = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expected_rsps.push_back(apply_list_op(pending_reqs.pop_front()));
        accepted++;
      end
      if (in_valid && in_stall) begin
        // hold payload
      end else if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if ((!in_valid || !in_stall) &&
                   pending_reqs.size() > (in_valid && !in_stall ? 0 : 0) &&
                   !hold_request) begin
        if (!quiet_tail && $urandom_range(0, 5) == 0) begin
          send_gap = $urandom_range(1, 12);
          in_valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          in_valid <= 1'b1;
          in_operation <= pending_reqs[0].op;
          in_value <= pending_reqs[0].value;
          in_position <= pending_reqs[0].pos;
        end else in_valid <= 1'b0;
      end else in_valid <= 1'b0;
    end
  end

  // monitor and receiver stall
  int stall_left = 0;
  int long_hold = 0;
  always @(posedge clk) begin
    list_rsp_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        checked++;
        if (expected_rsps.size() == 0) begin
          $display("unexpected result with status %0d", out_status);
          errors++;
        end else begin
          want = expected_rsps.pop_front();
          if (out_status !== want.status) report_mismatch("status", out_status, want.status);
          if (out_data !== want.data) report_mismatch("data", out_data, want.data);
          if (out_slot !== want.slot) report_mismatch("slot", out_slot, want.slot);
          if (out_count !== want.count) report_mismatch("count", out_count, want.count);
        end
      end
      if (long_hold > 0) begin
        long_hold--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (!quiet_tail && $urandom_range(0, 6) == 0) begin
        stall_left = $urandom_range(1, 12) - 1;
        out_stall <= 1'b1;
      end else out_stall <= 1'b0;
    end
  end

  function automatic list_req_t mk(logic [3:0] op, logic [31:0] v, logic [3:0] p);
    list_req_t r;
    r.op = op; r.value = v; r.pos = p;
    return r;
  endfunction

  // directed part, then random phases biased toward a well-populated list
  initial begin
    int fill;
    logic [3:0] op;
    for (int i = 0; i < NSLOT; i++) begin
      m_used[i] = 1'b0; m_data[i] = '0; m_next[i] = '0; m_prev[i] = '0;
    end
    m_head = '0; m_tail = '0; m_count = '0;
    pending_reqs.push_back(mk(abcl_pkg::OP_RD_HEAD, 0, 0));
    pending_reqs.push_back(mk(abcl_pkg::OP_REM_SLOT, 0, 0));
    pending_reqs.push_back(mk(abcl_pkg::OP_INSERT, 32'h1234, 0));
    pending_reqs.push_back(mk(abcl_pkg::OP_PUSH_BACK, 32'hFFFFFFFF, 4'hF));
    pending_reqs.push_back(mk(abcl_pkg::OP_PUSH_FRONT, 32'h0, 0));
    pending_reqs.push_back(mk(abcl_pkg::OP_INSERT, 32'hA5A5A5A5, 0));
    pending_reqs.push_back(mk(abcl_pkg::OP_INSERT, 32'h5A5A5A5A, 2));
    pending_reqs.push_back(mk(abcl_pkg::OP_INSERT, 32'h77, 1));
    pending_reqs.push_back(mk(abcl_pkg::OP_INSERT, 32'h88, 4'hF));
    pending_reqs.push_back(mk(abcl_pkg::OP_RD_SLOT, 0, 1));
    pending_reqs.push_back(mk(abcl_pkg::OP_RD_SLOT, 0, 4'hF));
    pending_reqs.push_back(mk(abcl_pkg::OP_RD_HEAD, 0, 0));
    pending_reqs.push_back(mk(abcl_pkg::OP_RD_TAIL, 0, 0));
    pending_reqs.push_back(mk(abcl_pkg::OP_REM_SLOT, 0, 2));
    pending_reqs.push_back(mk(abcl_pkg::OP_REM_HEAD, 0, 0));
    pending_reqs.push_back(mk(abcl_pkg::OP_REM_TAIL, 0, 0));
    pending_reqs.push_back(mk(4'hA, 32'hDEAD, 3));
    pending_reqs.push_back(mk(4'hF, 0, 0));
    for (int i = 0; i < NSLOT + 1; i++)
      pending_reqs.push_back(mk(abcl_pkg::OP_PUSH_BACK, $urandom, 0));
    pending_reqs.push_back(mk(abcl_pkg::OP_INSERT, 32'h99, 5));
    pending_reqs.push_back(mk(abcl_pkg::OP_CLEAR, 0, 0));
    pending_reqs.push_back(mk(abcl_pkg::OP_REM_TAIL, 0, 0));
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    // random phases: fill to a random depth then mixed traffic
    for (int ph = 0; ph < 12; ph++) begin
      fill = $urandom_range(0, NSLOT + 1);
      for (int i = 0; i < fill; i++)
        pending_reqs.push_back(mk(4'($urandom_range(0, 1)), $urandom, 0));
      for (int i = 0; i < 35; i++) begin
        case ($urandom_range(0, 19))
          0, 1, 2, 3: op = abcl_pkg::OP_INSERT;
          4, 5: op = abcl_pkg::OP_PUSH_FRONT;
          6, 7: op = abcl_pkg::OP_PUSH_BACK;
          8, 9: op = abcl_pkg::OP_REM_SLOT;
          10: op = abcl_pkg::OP_REM_HEAD;
          11: op = abcl_pkg::OP_REM_TAIL;
          12, 13: op = abcl_pkg::OP_RD_SLOT;
          14: op = abcl_pkg::OP_RD_HEAD;
          15: op = abcl_pkg::OP_RD_TAIL;
          16: op = abcl_pkg::OP_CLEAR;
          17: op = 4'($urandom_range(10, 15));
          default: op = 4'($urandom_range(0, 9));
        endcase
        pending_reqs.push_back(mk(op, $urandom, 4'($urandom_range(0, 15))));
      end
      if (ph == 4) begin
        // long receiver hold-off while the sender keeps offering
        wait (pending_reqs.size() < 40);
        long_hold = 300;
      end
    end
    // last stretch runs with no idling on either side
    wait (pending_reqs.size() < 50);
    quiet_tail = 1'b1;
    stim_done = 1'b1;
  end

  // end of run
  initial begin
    wait (rst_n && stim_done && pending_reqs.size() == 0 && !in_valid);
    wait (expected_rsps.size() == 0);
    repeat (50) @(posedge clk);
    $display("ran %0d list operations, %0d results checked, %0d errors",
             accepted, checked, errors);
    $display("covered pushes, inserts, removes, reads, clear, full, empty and bad codes");
    if (errors == 0 && expected_rsps.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  initial begin
    #20ms;
    $display("FAIL");
    $finish;
  end
endmodule
`default_nettype wire
